// ===== sv/sdf_pkg.sv =====
// Shared types and constants for the signed decimal formatter.
// Used by sdf_digit_cell, sdf_cell_chain and signed_decimal_formatter; no dependencies.
package sdf_pkg;

   // Field widths
   localparam int VALUE_W  = 64;
   localparam int PREC_W   = 6;
   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;

   // Decimal digit cells; 2^63 needs 19 digits
   localparam int NUM_DIGITS = 20;
   localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
   localparam int POS_W      = $clog2(NUM_DIGITS);
   localparam int BIT_CNT_W  = $clog2(VALUE_W);

   // Precision above this saturates
   localparam logic [PREC_W-1:0] MAX_PRECISION = PREC_W'(32);

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SETUP,
      ST_EMIT
   } state_type;

   // Per-cycle command shared by every digit cell
   typedef struct packed {
      logic clear;   // zero the digit
      logic dabble;  // add-3 correction then shift in the neighbor's carry
      logic shift;   // take the lower neighbor's digit
   } cell_ctrl_type;

endpackage

// ===== sv/signed_decimal_formatter.sv =====
// Signed 64-bit integer to ASCII decimal text, one character per response.
// Each request is loaded, then converted by bit-serial double-dabble in a row of
// 20 BCD digit cells; a setup step then sends the minus sign of a negative value.
// The row then shifts until the leading digit reaches the top cell, and each digit
// is sent from the top cell; padding past 20 digits sends the extra leading zeros
// first. A stalled response holds the block. A precision above 32 is treated as
// 32. Precision 0 with value 0 yields one response with tuser (character valid) low
// and tlast high. The next request is taken once the last character sits in the
// output register.
// Depends on sdf_pkg and sdf_cell_chain.
module signed_decimal_formatter (
   input  logic        clock,
   input  logic        reset,
   // Requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] value, [69:64] precision, [71:70] zero
   // Responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_out
   output logic        rsp_tuser,   // [0] char_valid
   output logic        rsp_tlast
);

   localparam int PW = sdf_pkg::PREC_W;

   sdf_pkg::state_type       state_ff, state_in;
   logic [sdf_pkg::VALUE_W-1:0]   mag_ff, mag_in;
   logic [PW-1:0]                 prec_ff, prec_in;
   logic                          neg_ff, neg_in;
   logic [sdf_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [PW-1:0]                 remaining_ff, remaining_in;
   logic [sdf_pkg::POS_W-1:0]     top_pos_ff, top_pos_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sdf_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                          rsp_cv_ff, rsp_cv_in;
   logic                          rsp_last_ff, rsp_last_in;

   sdf_pkg::cell_ctrl_type        cell_ctrl;
   logic [sdf_pkg::DIGIT_W-1:0]   top_digit;
   logic                          all_zero;
   logic [sdf_pkg::CNT_W-1:0]     sig_count;

   logic                          req_fire;
   logic                          slot_free;
   logic [PW-1:0]                 req_prec;
   logic [sdf_pkg::VALUE_W-1:0]   req_value;
   logic [PW-1:0]                 ndig;
   logic                          is_empty;
   logic                          wide_pad;
   logic                          aligned;
   logic                          emit;
   logic [sdf_pkg::CHAR_W-1:0]    emit_char;
   logic                          emit_cv;
   logic                          emit_last;

   // Request fields
   assign req_value = req_tdata[63:0];
   assign req_prec  = req_tdata[69:64];
   assign req_tready = (state_ff == sdf_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Output register can take a new character
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Digit count after padding
   assign ndig = (prec_ff > PW'(sig_count)) ? prec_ff : PW'(sig_count);
   assign is_empty = (prec_ff == '0) && all_zero;

   // Padding beyond the cell row, and top cell holding the next digit
   assign wide_pad = (remaining_ff > PW'(sdf_pkg::NUM_DIGITS));
   assign aligned  = (PW'(top_pos_ff) == remaining_ff - PW'(1));

   sdf_cell_chain u_chain (
      .clock     (clock),
      .ctrl      (cell_ctrl),
      .serial_in (mag_ff[sdf_pkg::VALUE_W-1]),
      .top_digit (top_digit),
      .all_zero  (all_zero),
      .sig_count (sig_count)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdf_pkg::ST_IDLE: begin
            if (req_fire) state_in = sdf_pkg::ST_CONVERT;
         end
         sdf_pkg::ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_in = sdf_pkg::ST_SETUP;
         end
         sdf_pkg::ST_SETUP: begin
            if (is_empty) begin
               if (slot_free) state_in = sdf_pkg::ST_IDLE;
            end else if (!neg_ff || slot_free) begin
               state_in = sdf_pkg::ST_EMIT;
            end
         end
         sdf_pkg::ST_EMIT: begin
            if (!wide_pad && aligned && slot_free && remaining_ff == PW'(1)) begin
               state_in = sdf_pkg::ST_IDLE;
            end
         end
         default: state_in = sdf_pkg::ST_IDLE;
      endcase
   end

   // Per-state controls
   always_comb begin
      cell_ctrl = '0;
      emit      = 1'b0;
      emit_char = '0;
      emit_cv   = 1'b0;
      emit_last = 1'b0;
      case (state_ff)
         sdf_pkg::ST_IDLE: begin
            cell_ctrl.clear = req_fire;
         end
         sdf_pkg::ST_CONVERT: begin
            cell_ctrl.dabble = 1'b1;
         end
         sdf_pkg::ST_SETUP: begin
            if (is_empty) begin
               emit      = slot_free;
               emit_last = 1'b1;
            end else if (neg_ff) begin
               emit      = slot_free;
               emit_char = sdf_pkg::CHAR_MINUS;
               emit_cv   = 1'b1;
            end
         end
         sdf_pkg::ST_EMIT: begin
            if (wide_pad) begin
               emit      = slot_free;
               emit_char = sdf_pkg::CHAR_ZERO;
               emit_cv   = 1'b1;
            end else if (!aligned) begin
               cell_ctrl.shift = 1'b1;
            end else begin
               emit            = slot_free;
               cell_ctrl.shift = slot_free;
               emit_char       = sdf_pkg::CHAR_ZERO + sdf_pkg::CHAR_W'(top_digit);
               emit_cv         = 1'b1;
               emit_last       = (remaining_ff == PW'(1));
            end
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      mag_in       = mag_ff;
      prec_in      = prec_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      remaining_in = remaining_ff;
      top_pos_in   = top_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_fire) begin
         neg_in     = req_value[sdf_pkg::VALUE_W-1];
         mag_in     = req_value[sdf_pkg::VALUE_W-1] ? (~req_value + 64'd1) : req_value;
         prec_in    = (req_prec > sdf_pkg::MAX_PRECISION) ? sdf_pkg::MAX_PRECISION : req_prec;
         bit_cnt_in = sdf_pkg::BIT_CNT_W'(sdf_pkg::VALUE_W - 1);
         top_pos_in = sdf_pkg::POS_W'(sdf_pkg::NUM_DIGITS - 1);
      end

      if (cell_ctrl.dabble) begin
         mag_in     = {mag_ff[sdf_pkg::VALUE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - sdf_pkg::BIT_CNT_W'(1);
      end

      if (state_ff == sdf_pkg::ST_SETUP) begin
         remaining_in = ndig;
      end

      if (cell_ctrl.shift) begin
         top_pos_in = top_pos_ff - sdf_pkg::POS_W'(1);
      end

      if (emit && state_ff == sdf_pkg::ST_EMIT) begin
         remaining_in = remaining_ff - PW'(1);
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_cv_in    = emit_cv;
         rsp_last_in  = emit_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      prec_ff      <= prec_in;
      neg_ff       <= neg_in;
      bit_cnt_ff   <= bit_cnt_in;
      remaining_ff <= remaining_in;
      top_pos_ff   <= top_pos_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_cv_ff    <= rsp_cv_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_cv_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/sdf_digit_cell.sv =====
// One BCD digit cell of the conversion chain.
// Depends on sdf_pkg (cell_ctrl_type, DIGIT_W).
module sdf_digit_cell (
   input  logic                          clock,
   input  sdf_pkg::cell_ctrl_type        ctrl,
   input  logic                          carry_in,     // bit from lower cell
   input  logic [sdf_pkg::DIGIT_W-1:0]   lower_digit,  // digit of lower cell
   output logic                          carry_out,    // bit to upper cell
   output logic [sdf_pkg::DIGIT_W-1:0]   digit
);

   logic [sdf_pkg::DIGIT_W-1:0] digit_ff;
   logic [sdf_pkg::DIGIT_W-1:0] digit_in;
   logic [sdf_pkg::DIGIT_W-1:0] adjusted;

   // Add 3 when the digit would overflow past 9 after doubling
   assign adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adjusted[sdf_pkg::DIGIT_W-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.dabble) begin
         digit_in = {adjusted[sdf_pkg::DIGIT_W-2:0], carry_in};
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ===== sv/sdf_cell_chain.sv =====
// Row of BCD digit cells: double-dabble conversion and digit shift-out.
// Depends on sdf_pkg and sdf_digit_cell.
module sdf_cell_chain (
   input  logic                          clock,
   input  sdf_pkg::cell_ctrl_type        ctrl,
   input  logic                          serial_in,  // magnitude bit, MSB first
   output logic [sdf_pkg::DIGIT_W-1:0]   top_digit,  // most significant cell
   output logic                          all_zero,
   output logic [sdf_pkg::CNT_W-1:0]     sig_count   // significant digits, at least 1
);

   logic [sdf_pkg::DIGIT_W-1:0] cell_digit [sdf_pkg::NUM_DIGITS];
   logic                        cell_carry [sdf_pkg::NUM_DIGITS];

   // Cells: carry and digit pass from index i-1 to index i
   for (genvar i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin : g_cell
      logic                        c_in;
      logic [sdf_pkg::DIGIT_W-1:0] d_in;
      if (i == 0) begin : g_first
         assign c_in = serial_in;
         assign d_in = '0;
      end else begin : g_rest
         assign c_in = cell_carry[i-1];
         assign d_in = cell_digit[i-1];
      end
      sdf_digit_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .carry_in    (c_in),
         .lower_digit (d_in),
         .carry_out   (cell_carry[i]),
         .digit       (cell_digit[i])
      );
   end

   assign top_digit = cell_digit[sdf_pkg::NUM_DIGITS-1];

   // Highest nonzero digit gives the significant digit count
   always_comb begin
      sig_count = sdf_pkg::CNT_W'(1);
      all_zero  = 1'b1;
      for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
         if (cell_digit[i] != '0) begin
            sig_count = sdf_pkg::CNT_W'(i + 1);
            all_zero  = 1'b0;
         end
      end
   end

endmodule

// ===== verif/sdf_text_checker.sv =====
`timescale 1ns / 100ps
// Checker for signed_decimal_formatter: watches both stream channels, predicts the
// decimal text of every accepted request and compares each response character.
// Depends on sdf_pkg for field widths, the precision limit and the ASCII codes.
module sdf_text_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] value, [69:64] precision, [71:70] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] char_out
   input  logic        rsp_tuser,   // [0] char_valid
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending_count
);

   // One expected text character
   typedef struct packed {
      logic [sdf_pkg::CHAR_W-1:0] code;
      logic                       shown;
      logic                       fin;
   } text_char_type;

   text_char_type expected_chars[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Queue the full text of one request: sign, zero padding, then magnitude digits
   function automatic void predict_text(input logic [sdf_pkg::VALUE_W-1:0] value,
                                        input logic [sdf_pkg::PREC_W-1:0] prec_in);
      logic [sdf_pkg::PREC_W-1:0]  prec;
      logic                        neg;
      logic [sdf_pkg::VALUE_W-1:0] mag;
      logic [sdf_pkg::VALUE_W-1:0] rest;
      logic [sdf_pkg::DIGIT_W-1:0] dec_digit[sdf_pkg::NUM_DIGITS];
      int                          digit_total;
      int                          pad_len;
      int                          pos;
      text_char_type               c;
      prec = (prec_in > sdf_pkg::MAX_PRECISION) ? sdf_pkg::MAX_PRECISION : prec_in;
      neg  = value[sdf_pkg::VALUE_W-1];
      mag  = neg ? (~value + 64'd1) : value;
      foreach (dec_digit[i]) dec_digit[i] = '0;
      rest = mag;
      digit_total = 0;
      do begin
         dec_digit[digit_total] = sdf_pkg::DIGIT_W'(rest % 64'd10);
         rest = rest / 64'd10;
         digit_total++;
      end while (rest != 0 && digit_total < sdf_pkg::NUM_DIGITS);
      // Precision 0 on a zero value: empty text, one marker response
      if (prec == 0 && mag == 0) begin
         c = '{code: '0, shown: 1'b0, fin: 1'b1};
         expected_chars.push_back(c);
         return;
      end
      pad_len = (int'(prec) > digit_total) ? int'(prec) : digit_total;
      if (neg) begin
         c = '{code: sdf_pkg::CHAR_MINUS, shown: 1'b1, fin: 1'b0};
         expected_chars.push_back(c);
      end
      for (int i = 0; i < pad_len; i++) begin
         pos = pad_len - 1 - i;
         c.code  = sdf_pkg::CHAR_ZERO +
                   ((pos < sdf_pkg::NUM_DIGITS) ? sdf_pkg::CHAR_W'(dec_digit[pos]) : '0);
         c.shown = 1'b1;
         c.fin   = (i == pad_len - 1);
         expected_chars.push_back(c);
      end
   endfunction

   // Sample both channels at the clock edge
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_chars.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_text(req_tdata[63:0], req_tdata[69:64]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $error("response char_out %h with no character expected", rsp_tdata);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.code) begin
                  $error("char_out: expected %h, got %h", want.code, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.shown) begin
                  $error("char_valid: expected %b, got %b", want.shown, rsp_tuser);
                  error_count++;
               end
               if (rsp_tlast !== want.fin) begin
                  $error("last: expected %b, got %b", want.fin, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
      pending_count <= expected_chars.size();
   end

endmodule

// ===== verif/signed_decimal_formatter_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for signed_decimal_formatter: drives requests in bursts, stalls the
// response side, and reports the verdict. Depends on sdf_pkg and sdf_text_checker.
module signed_decimal_formatter_tb;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          error_count;
   int          pending_count;

   int          burst_left  = 0;
   int          stall_mode  = 0;
   int          mode_left   = 0;
   logic [1:0]  stall_phase = '0;

   always #5 clock = ~clock;

   signed_decimal_formatter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sdf_text_checker text_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Send one request; a new burst starts after a random gap, sometimes none, with tvalid low
   task automatic send_request(input logic [sdf_pkg::VALUE_W-1:0] value,
                               input logic [sdf_pkg::PREC_W-1:0] prec);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 150);
         burst_left = $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, prec, value};
      do @(posedge clock); while (!req_tready);
   endtask

   // Mix of wide random, short, near-zero and power-of-ten values, both signs
   function automatic logic [sdf_pkg::VALUE_W-1:0] pick_value();
      logic [sdf_pkg::VALUE_W-1:0] v;
      logic [sdf_pkg::VALUE_W-1:0] p10;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: ;
         1: v = v >> $urandom_range(1, 63);
         2: v = -(v >> $urandom_range(1, 63));
         3: v = 64'($urandom_range(0, 2000)) - 64'd1000;
         4: v = '0;
         default: begin
            p10 = 64'd1;
            repeat ($urandom_range(0, 18)) p10 = p10 * 64'd10;
            v = p10 + 64'($urandom_range(0, 2)) - 64'd1;
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // Mostly short precisions, some wide ones, some past the saturation point
   function automatic logic [sdf_pkg::PREC_W-1:0] pick_prec();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return sdf_pkg::PREC_W'($urandom_range(0, 8));
      if (r < 8) return sdf_pkg::PREC_W'($urandom_range(9, 32));
      return sdf_pkg::PREC_W'($urandom_range(33, 63));
   endfunction

   // Response side: segments of always-ready, random, periodic and heavy stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left  <= 0;
      end else begin
         stall_phase <= stall_phase + 2'd1;
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 1);
            2:       rsp_tready <= (stall_phase == 2'd0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   initial begin
      int drain_cycles;
      drain_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty text, zero padding, saturation, extremes of both signs
      send_request(64'd0, 6'd0);
      send_request(64'd0, 6'd1);
      send_request(64'd0, 6'd63);
      send_request(64'd7, 6'd0);
      send_request(-64'd7, 6'd0);
      send_request(64'h7FFF_FFFF_FFFF_FFFF, 6'd1);
      send_request(64'h7FFF_FFFF_FFFF_FFFF, 6'd63);
      send_request(64'h8000_0000_0000_0000, 6'd0);
      send_request(64'h8000_0000_0000_0000, 6'd32);
      send_request(-64'd1, 6'd32);
      send_request(-64'd1, 6'd33);
      send_request(64'd1, 6'd19);
      send_request(64'd1, 6'd20);
      send_request(64'd1, 6'd21);
      send_request(64'd999_999_999_999_999_999, 6'd18);
      send_request(64'd1_000_000_000_000_000_000, 6'd19);
      send_request(-64'd12345, 6'd3);
      send_request(64'd12345, 6'd10);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 6'd42);
      send_request(64'h5555_5555_5555_5555, 6'd21);
      send_request(64'd10, 6'd2);
      send_request(-64'd10, 6'd1);

      // Random requests
      for (int n = 0; n < 350; n++)
         send_request(pick_value(), pick_prec());
      req_tvalid <= 1'b0;

      // Drain outstanding characters, then let the pipeline settle
      @(posedge clock);
      while (pending_count != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (150) @(posedge clock);
      if (pending_count != 0)
         $error("%0d expected characters never arrived", pending_count);

      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
